// ----- design/per_host_ip_traffic_counter_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef PER_HOST_IP_TRAFFIC_COUNTER_DEFINES_SVH
`define PER_HOST_IP_TRAFFIC_COUNTER_DEFINES_SVH

// Checked on every rising clk edge, muted while rst_n is low.
`define PHITC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define PHITC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/phitc_pkg.sv -----
package phitc_pkg;

  // Default sizing handed to the top level
  localparam int HOSTS_DEF           = 256;
  localparam int PAGES_DEF           = 2;
  localparam int BYTE_COUNT_BITS_DEF = 48;

  // Fixed field widths
  localparam int CAT_W      = 3;
  localparam int HOST_W     = 8;
  localparam int BYTE_OUT_W = 48;
  localparam int PKT_W      = 32;
  localparam int ADDR_W     = 32;
  localparam int ETH_W      = 16;
  localparam int LEN_W      = 16;
  localparam int TS_W       = 32;
  localparam int NET_W      = 8;
  localparam int CATS       = 4;

  // Protocol constants
  localparam logic [ETH_W-1:0] ETH_IPV4      = 16'h0800;
  localparam logic [ETH_W-1:0] ETH_VLAN      = 16'h8100;
  localparam logic [NET_W-1:0] BCAST_LOW     = 8'd255;
  localparam logic [NET_W-1:0] MCAST_LO      = 8'd224;
  localparam logic [NET_W-1:0] MCAST_HI      = 8'd239;
  localparam logic [NET_W-1:0] LOCAL_NET_RST = 8'd10;

  // Register map, indexed by paddr[2]
  localparam logic REG_PAGE_SELECT = 1'b0;
  localparam logic REG_LOCAL_NET   = 1'b1;

  typedef enum logic [CAT_W-1:0] {
    CAT_NOT_IP = 3'd0,
    CAT_LOCAL  = 3'd1,
    CAT_BCAST  = 3'd2,
    CAT_MCAST  = 3'd3,
    CAT_RX     = 3'd4,
    CAT_TX     = 3'd5
  } cat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic capture;
    logic update;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

// ----- design/phitc_ram.sv -----
module phitc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/phitc_regs.sv -----
module phitc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic                         page_select,
  output logic [phitc_pkg::NET_W-1:0]  local_net
);
  import phitc_pkg::*;

  logic             page_select_r, page_select_nxt;
  logic [NET_W-1:0] local_net_r, local_net_nxt;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // Register writes
  always_comb begin
    page_select_nxt = page_select_r;
    local_net_nxt   = local_net_r;
    if (wr) begin
      case (paddr[2])
        REG_PAGE_SELECT: page_select_nxt = pwdata[0];
        REG_LOCAL_NET:   local_net_nxt   = pwdata[NET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_select_r <= 1'b0;
      local_net_r   <= LOCAL_NET_RST;
    end else begin
      page_select_r <= page_select_nxt;
      local_net_r   <= local_net_nxt;
    end
  end

  // Readback
  always_comb begin
    case (paddr[2])
      REG_PAGE_SELECT: prdata = {31'b0, page_select_r};
      REG_LOCAL_NET:   prdata = {{(32-NET_W){1'b0}}, local_net_r};
      default:         prdata = '0;
    endcase
  end

  assign page_select = page_select_r;
  assign local_net   = local_net_r;

endmodule

// ----- design/phitc_ctrl.sv -----
module phitc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  phitc_pkg::dp_status_t  status,
  output phitc_pkg::ctrl_cmd_t   cmd
);
  import phitc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output slot is free if empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (status.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_UPDATE;
      ST_UPDATE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_UPDATE: begin
        cmd.update = out_free;
      end
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/phitc_dp.sv -----
module phitc_dp #(
  parameter int HOSTS           = phitc_pkg::HOSTS_DEF,
  parameter int PAGES           = phitc_pkg::PAGES_DEF,
  parameter int BYTE_COUNT_BITS = phitc_pkg::BYTE_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  phitc_pkg::ctrl_cmd_t              cmd,
  output phitc_pkg::dp_status_t             status,
  input  logic                              page_select,
  input  logic [phitc_pkg::NET_W-1:0]       local_net,
  input  logic [phitc_pkg::ETH_W-1:0]       in_ether_type,
  input  logic [phitc_pkg::ADDR_W-1:0]      in_src_addr,
  input  logic [phitc_pkg::ADDR_W-1:0]      in_dst_addr,
  input  logic [phitc_pkg::LEN_W-1:0]       in_ip_length,
  input  logic [phitc_pkg::TS_W-1:0]        in_timestamp,
  output logic [phitc_pkg::CAT_W-1:0]       out_category,
  output logic [phitc_pkg::HOST_W-1:0]      out_host_index,
  output logic [phitc_pkg::BYTE_OUT_W-1:0]  out_byte_total,
  output logic [phitc_pkg::PKT_W-1:0]       out_packet_total
);
  import phitc_pkg::*;

  localparam int SEEN_DEPTH = PAGES * HOSTS;
  localparam int CNT_DEPTH  = SEEN_DEPTH * CATS;
  localparam int SEEN_AW    = $clog2(SEEN_DEPTH);
  localparam int CNT_AW     = SEEN_AW + 2;
  localparam int CNT_W      = BYTE_COUNT_BITS + PKT_W;

  // Classification of the incoming packet
  logic [NET_W-1:0]  src_net, dst_net, src_low, dst_low;
  logic              is_ip, both_local, hit;
  cat_t              cat;
  logic [HOST_W-1:0] host;
  logic [SEEN_AW-1:0] hslot;
  logic [1:0]        cat_off;
  logic [CNT_AW-1:0] cnt_addr;
  logic [CAT_W-1:0]  cat_diff;

  assign src_net = in_src_addr[ADDR_W-1 -: NET_W];
  assign dst_net = in_dst_addr[ADDR_W-1 -: NET_W];
  assign src_low = in_src_addr[NET_W-1:0];
  assign dst_low = in_dst_addr[NET_W-1:0];

  always_comb begin
    is_ip      = (in_ether_type == ETH_IPV4) || (in_ether_type == ETH_VLAN);
    both_local = (src_net == local_net) && (dst_net == local_net);
    host       = '0;
    if (!is_ip) begin
      cat = CAT_NOT_IP;
    end else if (both_local) begin
      cat = CAT_LOCAL;
    end else if (dst_low == BCAST_LOW) begin
      cat  = CAT_BCAST;
      host = src_low;
    end else if (dst_net inside {[MCAST_LO:MCAST_HI]}) begin
      cat  = CAT_MCAST;
      host = src_low;
    end else if (src_net != local_net) begin
      cat  = CAT_RX;
      host = dst_low;
    end else begin
      cat  = CAT_TX;
      host = src_low;
    end
    hit = is_ip && !both_local && ({1'b0, host} < (HOST_W + 1)'(HOSTS));
  end

  // Table address: page, host, category
  always_comb begin
    logic [SEEN_AW-1:0] page;
    page     = (PAGES == 1) ? '0 : SEEN_AW'(page_select);
    hslot    = SEEN_AW'(page * SEEN_AW'(HOSTS)) + SEEN_AW'(host);
    cat_diff = cat - CAT_BCAST;
    cat_off  = cat_diff[1:0];
    cnt_addr = {hslot, cat_off};
  end

  // Item held across the update cycle
  cat_t                 cat_r;
  logic [HOST_W-1:0]    host_r;
  logic                 hit_r;
  logic [LEN_W-1:0]     len_r;
  logic [TS_W-1:0]      ts_r;
  logic [CNT_AW-1:0]    cnt_addr_r;
  logic [SEEN_AW-1:0]   seen_addr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cat_r       <= cat;
      host_r      <= host;
      hit_r       <= hit;
      len_r       <= in_ip_length;
      ts_r        <= in_timestamp;
      cnt_addr_r  <= cnt_addr;
      seen_addr_r <= hslot;
    end
  end

  // Post-reset clearing sweep
  logic [CNT_AW-1:0] clr_r, clr_nxt;

  assign clr_nxt           = cmd.clear ? clr_r + 1'b1 : clr_r;
  assign status.clear_last = (clr_r == CNT_AW'(CNT_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  // Counter read-modify-write
  logic [CNT_W-1:0]           cnt_rdata, cnt_wdata;
  logic [BYTE_COUNT_BITS-1:0] bytes_new;
  logic [PKT_W-1:0]           pkts_new;
  logic                       cnt_we, seen_we;
  logic [CNT_AW-1:0]          cnt_waddr;
  logic [SEEN_AW-1:0]         seen_waddr;
  logic [TS_W-1:0]            seen_wdata;
  logic [63:0]                bytes_wide;

  assign bytes_new  = cnt_rdata[CNT_W-1:PKT_W] + BYTE_COUNT_BITS'(len_r);
  assign pkts_new   = cnt_rdata[PKT_W-1:0] + 1'b1;
  assign bytes_wide = 64'(bytes_new);

  always_comb begin
    cnt_we     = cmd.update && hit_r;
    seen_we    = cnt_we;
    cnt_waddr  = cnt_addr_r;
    seen_waddr = seen_addr_r;
    cnt_wdata  = {bytes_new, pkts_new};
    seen_wdata = ts_r;
    if (cmd.clear) begin
      cnt_we     = 1'b1;
      seen_we    = 1'b1;
      cnt_waddr  = clr_r;
      seen_waddr = clr_r[CNT_AW-1:2];
      cnt_wdata  = '0;
      seen_wdata = '0;
    end
  end

  phitc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.capture),
    .raddr (cnt_addr),
    .rdata (cnt_rdata)
  );

  // Last-seen times are write only
  phitc_ram #(
    .WIDTH (TS_W),
    .DEPTH (SEEN_DEPTH)
  ) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_category     <= cat_r;
      out_host_index   <= host_r;
      out_byte_total   <= hit_r ? bytes_wide[BYTE_OUT_W-1:0] : '0;
      out_packet_total <= hit_r ? pkts_new : '0;
    end
  end

endmodule

// ----- design/per_host_ip_traffic_counter.sv -----
// A packet is captured in ST_IDLE; ST_UPDATE then does the counter RAM
// read-modify-write and loads the result register, waiting while the result is stalled.
// A new packet is not taken until the previous one has left ST_UPDATE (in_stall high).
// Reset (rst_n low, synchronous) clears control and registers (local_net to 10);
// then a clearing sweep over all PAGES*HOSTS*4 counter entries zeroes the
// tables, with in_stall high and configuration writes still taken.
module per_host_ip_traffic_counter #(
  parameter int HOSTS           = phitc_pkg::HOSTS_DEF,
  parameter int PAGES           = phitc_pkg::PAGES_DEF,
  parameter int BYTE_COUNT_BITS = phitc_pkg::BYTE_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [phitc_pkg::ETH_W-1:0]       in_ether_type,
  input  logic [phitc_pkg::ADDR_W-1:0]      in_src_addr,
  input  logic [phitc_pkg::ADDR_W-1:0]      in_dst_addr,
  input  logic [phitc_pkg::LEN_W-1:0]       in_ip_length,
  input  logic [phitc_pkg::TS_W-1:0]        in_timestamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [phitc_pkg::CAT_W-1:0]       out_category,
  output logic [phitc_pkg::HOST_W-1:0]      out_host_index,
  output logic [phitc_pkg::BYTE_OUT_W-1:0]  out_byte_total,
  output logic [phitc_pkg::PKT_W-1:0]       out_packet_total
);
  import phitc_pkg::*;

  logic             page_select;
  logic [NET_W-1:0] local_net;
  ctrl_cmd_t        cmd;
  dp_status_t       status;

  phitc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .page_select (page_select),
    .local_net   (local_net)
  );

  phitc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  phitc_dp #(
    .HOSTS           (HOSTS),
    .PAGES           (PAGES),
    .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .page_select      (page_select),
    .local_net        (local_net),
    .in_ether_type    (in_ether_type),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_ip_length     (in_ip_length),
    .in_timestamp     (in_timestamp),
    .out_category     (out_category),
    .out_host_index   (out_host_index),
    .out_byte_total   (out_byte_total),
    .out_packet_total (out_packet_total)
  );

endmodule

// ----- design/phitc_checker.sv -----
`include "per_host_ip_traffic_counter_defines.svh"

module phitc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [phitc_pkg::CAT_W-1:0]       out_category,
  input logic [phitc_pkg::HOST_W-1:0]      out_host_index,
  input logic [phitc_pkg::BYTE_OUT_W-1:0]  out_byte_total,
  input logic [phitc_pkg::PKT_W-1:0]       out_packet_total
);
  import phitc_pkg::*;

  // Stalled result stays put
  `PHITC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_category) && $stable(out_host_index) && $stable(out_byte_total) && $stable(out_packet_total), "stalled result changed")

  // Reset starts the clearing sweep with nothing pending
  `PHITC_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> in_stall && !out_valid, "block not busy after reset")

  // One packet in flight: an accepted transaction blocks the next cycle
  `PHITC_ASSERT(a_accept_busy, in_valid && !in_stall |=> in_stall, "input taken during update")

  // Uncounted packets report no host and no totals
  `PHITC_ASSERT(a_uncounted_zero, out_valid && (out_category == CAT_NOT_IP || out_category == CAT_LOCAL) |-> out_host_index == '0 && out_byte_total == '0 && out_packet_total == '0, "uncounted packet has totals")

endmodule

bind per_host_ip_traffic_counter phitc_checker u_phitc_checker (.*);
